// File: hdl/xed_pkg.sv
// Package for the XML character entity decoder: beat types, phase codes,
// character constants and the character-class helpers. No dependencies.
`timescale 1ns / 1ps

package xed_pkg;

    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned COUNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int unsigned SLOT_W      = $clog2(MAX_RESULTS);

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LESS  = 8'h3C;
    localparam logic [7:0] CH_MORE  = 8'h3E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Bytes still to drop once an entity has been recognised.
    localparam logic [2:0] DROP_LONG  = 3'd3;
    localparam logic [2:0] DROP_AMP   = 3'd2;
    localparam logic [2:0] DROP_SHORT = 3'd1;

    // Number of digits after which a numeric entity is complete.
    localparam logic [1:0] DIGITS_MAX = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_AMP    = 3'd1,
        PH_LETTER = 3'd2,
        PH_HASH   = 3'd3,
        PH_DIGITS = 3'd4,
        PH_AFTER  = 3'd5,
        PH_SKIP   = 3'd6
    } xed_phase_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } xed_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last_of_run;
        logic       end_of_output;
    } xed_out_t;

    // All results caused by one input beat, handed from the decoder to the
    // result buffer.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [COUNT_W-1:0]          count;
        logic                        marker;
        logic                        last;
    } xed_batch_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] rep;
        logic [2:0] drop;
    } xed_match_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic is_start_letter(input logic [7:0] b);
        logic [7:0] l;
        l = b | CASE_BIT;
        return is_alpha(b) && ((l == "n") || (l == "q") || (l == "a") ||
                               (l == "l") || (l == "g") || (l == "e"));
    endfunction

    function automatic xed_match_t match_pair(input logic [7:0] first,
                                              input logic [7:0] second);
        xed_match_t m;
        logic [7:0] a;
        logic [7:0] b;
        a = first | CASE_BIT;
        b = second | CASE_BIT;
        m = '0;
        if (is_alpha(second)) begin
            if (a == "n" && b == "b") m = '{1'b1, CH_SPACE, DROP_LONG};
            else if (a == "q" && b == "u") m = '{1'b1, CH_QUOTE, DROP_LONG};
            else if (a == "a" && b == "m") m = '{1'b1, CH_AMP, DROP_AMP};
            else if (a == "l" && b == "t") m = '{1'b1, CH_LESS, DROP_SHORT};
            else if (a == "g" && b == "t") m = '{1'b1, CH_MORE, DROP_SHORT};
            else if (a == "e" && b == "u") m = '{1'b1, CH_COLON, DROP_LONG};
        end
        return m;
    endfunction

endpackage

// File: hdl/xed_core.sv
// Entity recognition state and the per-beat decode into a batch of results.
// Depends on xed_pkg.
`timescale 1ns / 1ps

module xed_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  xed_pkg::xed_in_t    text,
    output xed_pkg::xed_batch_t batch
);
    import xed_pkg::*;

    xed_phase_t  phase_reg,  phase_next;
    logic [7:0]  held_reg,   held_next;
    logic [7:0]  value_reg,  value_next;
    logic [1:0]  digits_reg, digits_next;
    logic [2:0]  skip_reg,   skip_next;

    always_comb
    begin
        logic [7:0]                  b;
        logic [MAX_RESULTS-1:0][7:0] ob;
        logic [COUNT_W-1:0]          n;
        xed_match_t                  m;
        logic [7:0]                  acc;

        b   = text.text_byte;
        ob  = '0;
        n   = '0;
        m   = match_pair(held_reg, b);
        acc = (value_reg << 3) + (value_reg << 1) + (b - CH_ZERO);

        phase_next  = phase_reg;
        held_next   = held_reg;
        value_next  = value_reg;
        digits_next = digits_reg;
        skip_next   = skip_reg;

        unique case (phase_reg)
            PH_AMP:
            begin
                if (b == CH_HASH)
                begin
                    phase_next = PH_HASH;
                end
                else if (is_start_letter(b))
                begin
                    held_next  = b;
                    phase_next = PH_LETTER;
                end
                else
                begin
                    ob[n[SLOT_W-1:0]] = CH_AMP; n = n + COUNT_W'(1);
                    if (b == CH_AMP)
                        phase_next = PH_AMP;
                    else
                    begin
                        phase_next = PH_IDLE;
                        ob[n[SLOT_W-1:0]] = b; n = n + COUNT_W'(1);
                    end
                end
            end
            PH_LETTER:
            begin
                if (m.hit)
                begin
                    ob[n[SLOT_W-1:0]] = m.rep; n = n + COUNT_W'(1);
                    skip_next  = m.drop;
                    phase_next = PH_SKIP;
                end
                else
                begin
                    ob[n[SLOT_W-1:0]] = CH_AMP;   n = n + COUNT_W'(1);
                    ob[n[SLOT_W-1:0]] = held_reg; n = n + COUNT_W'(1);
                    if (b == CH_AMP)
                        phase_next = PH_AMP;
                    else
                    begin
                        phase_next = PH_IDLE;
                        ob[n[SLOT_W-1:0]] = b; n = n + COUNT_W'(1);
                    end
                end
            end
            PH_HASH:
            begin
                if (is_digit(b))
                begin
                    value_next  = b - CH_ZERO;
                    digits_next = 2'd1;
                    phase_next  = PH_DIGITS;
                end
                else
                begin
                    ob[n[SLOT_W-1:0]] = CH_AMP;  n = n + COUNT_W'(1);
                    ob[n[SLOT_W-1:0]] = CH_HASH; n = n + COUNT_W'(1);
                    if (b == CH_AMP)
                        phase_next = PH_AMP;
                    else
                    begin
                        phase_next = PH_IDLE;
                        ob[n[SLOT_W-1:0]] = b; n = n + COUNT_W'(1);
                    end
                end
            end
            PH_DIGITS:
            begin
                if (is_digit(b))
                begin
                    value_next  = acc;
                    digits_next = digits_reg + 2'd1;
                    if (digits_next >= DIGITS_MAX)
                    begin
                        ob[n[SLOT_W-1:0]] = acc; n = n + COUNT_W'(1);
                        phase_next = PH_AFTER;
                    end
                end
                else
                begin
                    ob[n[SLOT_W-1:0]] = value_reg; n = n + COUNT_W'(1);
                    if (b == CH_SEMI)
                        phase_next = PH_IDLE;
                    else if (b == CH_AMP)
                        phase_next = PH_AMP;
                    else
                    begin
                        phase_next = PH_IDLE;
                        ob[n[SLOT_W-1:0]] = b; n = n + COUNT_W'(1);
                    end
                end
            end
            PH_AFTER:
            begin
                if (b == CH_SEMI)
                    phase_next = PH_IDLE;
                else if (b == CH_AMP)
                    phase_next = PH_AMP;
                else
                begin
                    phase_next = PH_IDLE;
                    ob[n[SLOT_W-1:0]] = b; n = n + COUNT_W'(1);
                end
            end
            PH_SKIP:
            begin
                if (skip_reg != 3'd0)
                    skip_next = skip_reg - 3'd1;
                if (skip_next == 3'd0)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                if (b == CH_AMP)
                    phase_next = PH_AMP;
                else
                begin
                    phase_next = PH_IDLE;
                    ob[n[SLOT_W-1:0]] = b; n = n + COUNT_W'(1);
                end
            end
        endcase

        // End of string: flush whatever is held and start afresh.
        if (text.end_of_text)
        begin
            unique case (phase_next)
                PH_AMP:
                begin
                    ob[n[SLOT_W-1:0]] = CH_AMP; n = n + COUNT_W'(1);
                end
                PH_LETTER:
                begin
                    ob[n[SLOT_W-1:0]] = CH_AMP;    n = n + COUNT_W'(1);
                    ob[n[SLOT_W-1:0]] = held_next; n = n + COUNT_W'(1);
                end
                PH_HASH:
                begin
                    ob[n[SLOT_W-1:0]] = CH_AMP;  n = n + COUNT_W'(1);
                    ob[n[SLOT_W-1:0]] = CH_HASH; n = n + COUNT_W'(1);
                end
                PH_DIGITS:
                begin
                    ob[n[SLOT_W-1:0]] = value_next; n = n + COUNT_W'(1);
                end
                default:
                begin
                end
            endcase
            phase_next  = PH_IDLE;
            held_next   = '0;
            value_next  = '0;
            digits_next = '0;
            skip_next   = '0;
        end

        batch.bytes  = ob;
        batch.last   = text.end_of_text;
        batch.marker = text.end_of_text && (n == '0);
        batch.count  = batch.marker ? COUNT_W'(1) : n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            held_reg   <= '0;
            value_reg  <= '0;
            digits_reg <= '0;
            skip_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            held_reg   <= held_next;
            value_reg  <= value_next;
            digits_reg <= digits_next;
            skip_reg   <= skip_next;
        end
    end

endmodule

// File: hdl/xml_entity_decoder.sv
// Top level of the XML character entity decoder: input handshake, decode
// core and result buffer. Depends on xed_pkg and xed_core.
`timescale 1ns / 1ps

// The decoder takes text one byte per beat on the text channel and returns
// decoded characters on the dec channel. Named entities are recognised from
// their first two letters in either case (nbsp, quot, amp, lt, gt, euro) and
// the rest of the name is dropped unread; "&#" with one to three decimal
// digits gives the value modulo 256, and a semicolon straight after the
// digits is dropped. Text that does not form an entity passes through. A
// beat with end_of_text set flushes anything held and closes the string;
// the last result of the string carries end_of_output, and a string that
// ends with nothing to show gives one empty marker with has_byte low. Each
// input beat is decoded in the cycle it is accepted and its results, zero to
// three of them, are loaded into a small result buffer that sends one per
// cycle while dec_stall is low. A new beat is accepted whenever the buffer is
// empty or its last result is leaving, so ordinary text runs at one byte per
// cycle without stalls, each result out in the cycle after its beat is taken;
// a beat with several results holds off the input until its last is leaving.
// There are no configuration registers and no memories.
module xml_entity_decoder (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             text_valid,
    output logic             text_stall,
    input  xed_pkg::xed_in_t text,
    output logic             dec_valid,
    input  logic             dec_stall,
    output xed_pkg::xed_out_t dec
);
    import xed_pkg::*;

    xed_batch_t                  batch;
    logic                        text_take;
    logic                        dec_take;

    // Result buffer: the bytes of one batch and a pointer to the next byte to send.
    logic [MAX_RESULTS-1:0][7:0] bytes_reg;
    logic [COUNT_W-1:0]          left_reg;
    logic [SLOT_W-1:0]           slot_reg;
    logic                        marker_reg;
    logic                        last_reg;

    assign dec_valid  = (left_reg != '0);
    assign dec_take   = dec_valid && !dec_stall;
    assign text_stall = (left_reg > COUNT_W'(1)) ||
                        ((left_reg == COUNT_W'(1)) && dec_stall);
    assign text_take  = text_valid && !text_stall;

    xed_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (text_take),
        .text  (text),
        .batch (batch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            slot_reg <= '0;
        end
        else if (text_take)
        begin
            left_reg <= batch.count;
            slot_reg <= '0;
        end
        else if (dec_take)
        begin
            left_reg <= left_reg - COUNT_W'(1);
            slot_reg <= slot_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_take)
        begin
            bytes_reg  <= batch.bytes;
            marker_reg <= batch.marker;
            last_reg   <= batch.last;
        end
    end

    assign dec.out_byte      = bytes_reg[slot_reg];
    assign dec.has_byte      = !marker_reg;
    assign dec.last_of_run   = (left_reg == COUNT_W'(1));
    assign dec.end_of_output = (left_reg == COUNT_W'(1)) && last_reg;

endmodule

// File: hdl/xed_checker.sv
// Port-level assertions for the XML character entity decoder, bound to the
// top level. Depends on xed_pkg and xml_entity_decoder.
`timescale 1ns / 1ps

module xed_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              text_valid,
    input logic              text_stall,
    input xed_pkg::xed_in_t  text,
    input logic              dec_valid,
    input logic              dec_stall,
    input xed_pkg::xed_out_t dec
);
    import xed_pkg::*;

    // A result held back by the receiver stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec_stall |=> dec_valid && $stable(dec))
        else $error("stalled result changed");

    // The empty marker only closes a string and carries no character.
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec.has_byte |->
            dec.end_of_output && dec.last_of_run && (dec.out_byte == 8'h00))
        else $error("malformed empty marker");

    // The end of the string is always the end of a beat's results.
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec.end_of_output |-> dec.last_of_run)
        else $error("end of output before end of run");

    // While more results of one beat remain, no new text is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec.last_of_run |-> text_stall)
        else $error("input accepted with results still pending");

endmodule

bind xml_entity_decoder xed_checker u_xed_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text),
    .dec_valid  (dec_valid),
    .dec_stall  (dec_stall),
    .dec        (dec)
);
